### sv/linear_convolution_fir_core_defines.svh
// assertion macros for the convolution fir core
// needs clk_i and rst_ni in the scope of every use
`ifndef LINEAR_CONVOLUTION_FIR_CORE_DEFINES_SVH
`define LINEAR_CONVOLUTION_FIR_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define LCF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define LCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/lcf_pkg.sv
// shared constants for the convolution fir core
// no dependencies
package lcf_pkg;

  // fixed field widths
  localparam int unsigned ResultW  = 36;
  localparam int unsigned TapCntW  = 5;
  localparam int unsigned CoefIdxW = 4;

  // item kinds carried on action_i
  localparam logic ActLoad   = 1'b0;
  localparam logic ActSample = 1'b1;

endpackage

### sv/lcf_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module lcf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/linear_convolution_fir_core.sv
// convolution fir core: streaming full linear convolution with loadable taps
// depends on lcf_pkg, lcf_ram and linear_convolution_fir_core_defines.svh
//
//   channel   handshake                   payload
//   -------   -------------------------   ---------------------------------------
//   in        in_valid_i / in_stall_o     action_i coef_index_i value_i last_sample_i
//   out       out_valid_o / out_stall_i   result_o last_output_o
//   cfg       cfg_valid_i / cfg_ready_o   cfg_data_i (tap_count)
//
// a load is taken while idle; a sample stalls the input until its sum, and every tail
//   output behind it, has been handed to the output register
// each output is one pass of the one shared multiply-accumulate, which walks every
//   delay line position while the line rotates past it
// reset clears the delay line, the sequencer and tap_count (to one); taps are not cleared
// a stalled output holds the finished sum in the output register; the core waits
//   only when a second sum is ready before the first one has gone
`include "linear_convolution_fir_core_defines.svh"

module linear_convolution_fir_core #(
  parameter int unsigned MAX_TAPS    = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // configuration
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [lcf_pkg::TapCntW-1:0]             cfg_data_i,
  // input items
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    action_i,
  input  logic [lcf_pkg::CoefIdxW-1:0]            coef_index_i,
  input  logic signed [SAMPLE_BITS-1:0]           value_i,
  input  logic                                    last_sample_i,
  // result items
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [lcf_pkg::ResultW-1:0]      result_o,
  output logic                                    last_output_o
);

  localparam int unsigned IdxW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned CntW    = $clog2(MAX_TAPS + 1);
  localparam int unsigned MaxStep = MAX_TAPS + 1;
  localparam int unsigned StepW   = $clog2(MAX_TAPS + 2);
  localparam int unsigned ProdW   = 2 * SAMPLE_BITS;
  localparam int unsigned SumW    = ProdW + CntW;
  localparam int unsigned AccW    = (SumW > lcf_pkg::ResultW) ? SumW : lcf_pkg::ResultW;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StFinish
  } state_e;

  state_e state_q, state_d;

  // configuration register
  logic [lcf_pkg::TapCntW-1:0] tap_q;
  logic [CntW-1:0]             m_eff;

  // sequencer
  logic [StepW-1:0] step_q, step_d;
  logic [CntW-1:0]  tail_q, tail_d;
  logic             last_q, last_d;
  logic             p1_q, p2_q;

  // output register
  logic                               out_valid_q, out_valid_d;
  logic signed [lcf_pkg::ResultW-1:0] out_result_q, out_result_d;
  logic                               out_last_q, out_last_d;

  // datapath
  logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0] dl_q;
  logic signed [SAMPLE_BITS-1:0]        hd_q;
  logic signed [ProdW-1:0]              prod_q;
  logic signed [AccW-1:0]               acc_q;
  logic [SAMPLE_BITS-1:0]               coef_rd;

  logic                   in_xfer, slot_free, issue, tap_en;
  logic                   dl_shift, dl_clear, acc_clr;
  logic [SAMPLE_BITS-1:0] dl_shift_val;
  logic                   ram_we;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;

  // taps in use, zero acts as one and anything beyond the line acts as the full line
  always_comb begin
    if (tap_q == '0) begin
      m_eff = CntW'(1);
    end else if (32'(tap_q) > MAX_TAPS) begin
      m_eff = CntW'(MAX_TAPS);
    end else begin
      m_eff = CntW'(tap_q);
    end
  end

  // one tap per step while the line rotates; only the first m_eff steps count
  assign issue  = (state_q == StRun) && (32'(step_q) < MAX_TAPS);
  assign tap_en = 32'(step_q) < 32'(m_eff);

  // load transfers write the tap memory; out-of-range indexes are dropped
  assign ram_we = in_xfer && (action_i == lcf_pkg::ActLoad) && (32'(coef_index_i) < MAX_TAPS);

  lcf_ram #(
    .Width (SAMPLE_BITS),
    .Depth (MAX_TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IdxW'(coef_index_i)),
    .wdata_i (value_i),
    .raddr_i (step_q[IdxW-1:0]),
    .rdata_o (coef_rd)
  );

  // sequencer next state
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    tail_d       = tail_q;
    last_d       = last_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_result_d = out_result_q;
    out_last_d   = out_last_q;
    dl_shift     = 1'b0;
    dl_shift_val = value_i;
    dl_clear     = 1'b0;
    acc_clr      = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_xfer && (action_i == lcf_pkg::ActSample)) begin
          dl_shift = 1'b1;
          acc_clr  = 1'b1;
          step_d   = '0;
          last_d   = last_sample_i;
          tail_d   = last_sample_i ? (m_eff - CntW'(1)) : '0;
          state_d  = StRun;
        end
      end
      StRun: begin
        step_d = step_q + StepW'(1);
        if (32'(step_q) == MaxStep) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_result_d = acc_q[lcf_pkg::ResultW-1:0];
          out_last_d   = last_q && (tail_q == '0);
          if (tail_q != '0) begin
            // feed one zero for the next tail output
            tail_d       = tail_q - CntW'(1);
            dl_shift     = 1'b1;
            dl_shift_val = '0;
            acc_clr      = 1'b1;
            step_d       = '0;
            state_d      = StRun;
          end else begin
            dl_clear = last_q;
            state_d  = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      tap_q        <= lcf_pkg::TapCntW'(1);
      step_q       <= '0;
      tail_q       <= '0;
      last_q       <= 1'b0;
      p1_q         <= 1'b0;
      p2_q         <= 1'b0;
      out_valid_q  <= 1'b0;
      out_result_q <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      tail_q       <= tail_d;
      last_q       <= last_d;
      p1_q         <= issue && tap_en;
      p2_q         <= p1_q;
      out_valid_q  <= out_valid_d;
      out_result_q <= out_result_d;
      out_last_q   <= out_last_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tap_q <= cfg_data_i;
      end
    end
  end

  // delay line: clear after a sequence, shift on a new sample or tail zero, rotate one place per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_q <= '0;
    end else if (dl_clear) begin
      dl_q <= '0;
    end else if (dl_shift) begin
      for (int i = MAX_TAPS - 1; i > 0; i--) begin
        dl_q[i] <= dl_q[i-1];
      end
      dl_q[0] <= dl_shift_val;
    end else if (issue) begin
      for (int i = 0; i < MAX_TAPS - 1; i++) begin
        dl_q[i] <= dl_q[i+1];
      end
      dl_q[MAX_TAPS-1] <= dl_q[0];
    end
  end

  // shared multiply-accumulate: head sample is registered so it lines up with the registered tap read
  always_ff @(posedge clk_i) begin
    hd_q <= dl_q[0];
    if (p1_q) begin
      prod_q <= $signed(coef_rd) * hd_q;
    end
    if (acc_clr) begin
      acc_q <= '0;
    end else if (p2_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_o      = out_result_q;
  assign last_output_o = out_last_q;

  // checks
  `LCF_ASSERT_SAME(a_idle_no_tail, !in_stall_o, tail_q == '0, "idle with tail outputs pending")
  `LCF_ASSERT_SAME(a_step_bound, state_q == StRun, 32'(step_q) <= MaxStep, "step past the end")
  `LCF_ASSERT_SAME(a_mac_in_run, p2_q, state_q == StRun, "accumulate outside a pass")
  `LCF_ASSERT_NEXT(a_tail_armed,
                   in_xfer && (action_i == lcf_pkg::ActSample) && last_sample_i,
                   tail_q == CntW'(m_eff - CntW'(1)), "tail count not armed")
  `LCF_ASSERT_NEXT(a_line_cleared,
                   state_q == StFinish && slot_free && tail_q == '0 && last_q,
                   dl_q == '0, "delay line not cleared after sequence")

endmodule

### test/fir_conv_checker.sv
`timescale 1ns / 1ps
// result checker for the convolution fir core: mirrors taps, delay line and tap count
// depends on lcf_pkg; hands its mismatch and outstanding-result counts to the top
module fir_conv_checker #(
  parameter int unsigned MAX_TAPS    = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [lcf_pkg::TapCntW-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic                                action_i,
  input  logic [lcf_pkg::CoefIdxW-1:0]        coef_index_i,
  input  logic signed [SAMPLE_BITS-1:0]       value_i,
  input  logic                                last_sample_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [lcf_pkg::ResultW-1:0]  result_i,
  input  logic                                last_output_i,
  output int unsigned                         mismatch_count_o,
  output int unsigned                         outputs_due_o,
  output int unsigned                         outputs_seen_o
);

  typedef struct {
    logic signed [lcf_pkg::ResultW-1:0] conv_sum;
    logic                               is_last;
  } conv_out_t;

  conv_out_t                     conv_due_q[$];
  logic signed [SAMPLE_BITS-1:0] taps[MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] delay_line[MAX_TAPS];
  logic [lcf_pkg::TapCntW-1:0]   tap_count;
  int unsigned                   mismatches   = 0;
  int unsigned                   results_seen = 0;

  // tap count as the core applies it: zero acts as one, large values clamp
  function automatic int unsigned taps_active();
    if (tap_count == 0) return 1;
    if (tap_count > MAX_TAPS) return MAX_TAPS;
    return 32'(tap_count);
  endfunction

  // shift one sample into the line and queue the sum of products it gives
  function automatic void shift_and_queue(input logic signed [SAMPLE_BITS-1:0] sample,
                                          input logic flag);
    longint    acc;
    int        i;
    conv_out_t item;
    acc = 0;
    for (i = MAX_TAPS - 1; i > 0; i--) delay_line[i] = delay_line[i-1];
    delay_line[0] = sample;
    for (i = 0; i < int'(taps_active()); i++)
      acc += longint'(taps[i]) * longint'(delay_line[i]);
    item.conv_sum = acc[lcf_pkg::ResultW-1:0];
    item.is_last  = flag;
    conv_due_q.push_back(item);
  endfunction

  // one sample transfer; a closing sample flushes the tail with zeros
  function automatic void convolve_sample(input logic signed [SAMPLE_BITS-1:0] sample,
                                          input logic closes_seq);
    int unsigned m;
    int unsigned t;
    m = taps_active();
    shift_and_queue(sample, closes_seq && m == 1);
    if (closes_seq) begin
      for (t = 1; t < m; t++) shift_and_queue('0, t == m - 1);
      foreach (delay_line[k]) delay_line[k] = '0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    conv_out_t want;
    if (!rst_ni) begin
      tap_count = lcf_pkg::TapCntW'(1);
      foreach (delay_line[k]) delay_line[k] = '0;
      conv_due_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) tap_count = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        if (action_i == lcf_pkg::ActLoad) begin
          if (coef_index_i < MAX_TAPS) taps[coef_index_i] = value_i;
        end else begin
          convolve_sample(value_i, last_sample_i);
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (conv_due_q.size() == 0) begin
          $error("unexpected result transfer: result %0d last_output %0b",
                 result_i, last_output_i);
          mismatches++;
        end else begin
          want = conv_due_q.pop_front();
          if (result_i !== want.conv_sum) begin
            $error("result: expected %0d, got %0d", $signed(want.conv_sum), result_i);
            mismatches++;
          end
          if (last_output_i !== want.is_last) begin
            $error("last_output: expected %0b, got %0b", want.is_last, last_output_i);
            mismatches++;
          end
          results_seen++;
        end
      end
    end
    mismatch_count_o <= mismatches;
    outputs_due_o    <= conv_due_q.size();
    outputs_seen_o   <= results_seen;
  end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// stimulus and verdict for the convolution fir core
// depends on lcf_pkg, linear_convolution_fir_core and fir_conv_checker
module testbench;

  localparam int unsigned MAX_TAPS        = 16;
  localparam int unsigned SAMPLE_BITS     = 16;
  localparam int unsigned CLK_PERIOD      = 10;
  localparam int unsigned RESET_CYCLES    = 11;
  // quiet margin after the last result before the next register write
  localparam int unsigned SETTLE_CYCLES   = 2 * MAX_TAPS + 8;
  // longest quiet stretch: a full tail output plus the longest receiver stall,
  // or a settle pause, taken many times over
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned RANDOM_ITEMS    = 120;
  localparam int unsigned NUM_PHASES      = 9;
  localparam int unsigned ITEMS_PER_PHASE = RANDOM_ITEMS / NUM_PHASES;

  typedef enum logic [1:0] {
    StallNever,
    StallCoin,
    StallLong
  } stall_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // every block input starts at a known value
  logic                               cfg_valid_i   = 1'b0;
  logic                               cfg_ready_o;
  logic [lcf_pkg::TapCntW-1:0]        cfg_data_i    = '0;
  logic                               in_valid_i    = 1'b0;
  logic                               in_stall_o;
  logic                               action_i      = lcf_pkg::ActLoad;
  logic [lcf_pkg::CoefIdxW-1:0]       coef_index_i  = '0;
  logic signed [SAMPLE_BITS-1:0]      value_i       = '0;
  logic                               last_sample_i = 1'b0;
  logic                               out_valid_o;
  logic                               out_stall_i   = 1'b0;
  logic signed [lcf_pkg::ResultW-1:0] result_o;
  logic                               last_output_o;

  int unsigned mismatch_count;
  int unsigned outputs_due;
  int unsigned outputs_seen;

  // sender pacing and run bookkeeping
  bit          steady_mode  = 1'b0;
  int unsigned burst_left   = 0;
  int unsigned loads_sent   = 0;
  int unsigned samples_sent = 0;
  int unsigned quiet_cycles = 0;

  stall_mode_e stall_mode = StallNever;
  int unsigned mode_left  = 0;
  int unsigned hold_left  = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  linear_convolution_fir_core #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .coef_index_i (coef_index_i),
    .value_i      (value_i),
    .last_sample_i(last_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (result_o),
    .last_output_o(last_output_o)
  );

  fir_conv_checker #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .action_i        (action_i),
    .coef_index_i    (coef_index_i),
    .value_i         (value_i),
    .last_sample_i   (last_sample_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_i        (result_o),
    .last_output_i   (last_output_o),
    .mismatch_count_o(mismatch_count),
    .outputs_due_o   (outputs_due),
    .outputs_seen_o  (outputs_seen)
  );

  // receiver back-pressure: switch at random between no stall, coin-flip stall and long
  // held stalls, so stalls land on every phase of a tail
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 2));
      mode_left  <= $urandom_range(20, 120);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      StallNever: begin
        out_stall_i <= 1'b0;
      end
      StallCoin: begin
        out_stall_i <= ($urandom_range(0, 1) == 0);
      end
      default: begin
        if (hold_left == 0) begin
          out_stall_i <= ~out_stall_i;
          hold_left   <= $urandom_range(1, 30);
        end else begin
          hold_left <= hold_left - 1;
        end
      end
    endcase
  end

  // watchdog: any transfer on any channel restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, outputs_due);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input transfer; called right after a rising edge, returns right after
  // the edge that took it; valid stays high into the next item of a burst
  task automatic send_item(input logic act, input int unsigned idx,
                           input logic signed [SAMPLE_BITS-1:0] val, input logic closes);
    if (!steady_mode) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    coef_index_i  <= lcf_pkg::CoefIdxW'(idx);
    value_i       <= val;
    last_sample_i <= closes;
    do @(posedge clk_i); while (in_stall_o);
    if (act == lcf_pkg::ActLoad) loads_sent++;
    else samples_sent++;
  endtask

  // hold the sender until every queued result is out, then let a trailing load finish
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outputs_due != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write, only issued while the core is idle
  task automatic write_tap_count(input logic [lcf_pkg::TapCntW-1:0] taps);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= taps;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // sample or tap value: rails, small values around zero, or anything
  function automatic logic signed [SAMPLE_BITS-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return SAMPLE_BITS'($urandom_range(0, 16) - 8);
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  initial begin
    logic [lcf_pkg::TapCntW-1:0] phase_taps[NUM_PHASES];
    int unsigned                 p;
    int unsigned                 i;
    int unsigned                 k;
    int unsigned                 sent;
    int unsigned                 seq_len;
    bit                          paused;

    paused = 1'b0;
    // extremes first: zero and thirty-one are out of range and clamp
    phase_taps[0] = '0;
    phase_taps[1] = lcf_pkg::TapCntW'(MAX_TAPS);
    phase_taps[2] = lcf_pkg::TapCntW'(1);
    phase_taps[3] = lcf_pkg::TapCntW'(31);
    for (i = 4; i < NUM_PHASES; i++) phase_taps[i] = lcf_pkg::TapCntW'($urandom_range(2, 30));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!rst_ni) @(posedge clk_i);

    // single tap at the reset tap count: no tail, the closing sample is flagged last;
    // the last flag on a load must be ignored
    send_item(lcf_pkg::ActLoad, 0, 16'sh8000, 1'b1);
    send_item(lcf_pkg::ActSample, 15, 16'sh8000, 1'b0);
    send_item(lcf_pkg::ActSample, 0, 16'sh7FFF, 1'b1);
    wait_drained();

    // all sixteen taps at the rails, full-scale samples for the largest sums,
    // and a tap rewritten in the middle of the sequence
    write_tap_count(lcf_pkg::TapCntW'(MAX_TAPS));
    for (i = 1; i < MAX_TAPS; i++)
      send_item(lcf_pkg::ActLoad, i, (i % 2) ? 16'sh7FFF : 16'sh8000, 1'b0);
    send_item(lcf_pkg::ActSample, 5, 16'sh7FFF, 1'b0);
    send_item(lcf_pkg::ActSample, 10, 16'sh8000, 1'b0);
    send_item(lcf_pkg::ActLoad, 3, 16'sh0000, 1'b0);
    send_item(lcf_pkg::ActSample, 0, 16'sh8000, 1'b1);
    wait_drained();

    // random part: whole sequences with random content, loads mixed in now and then
    for (p = 0; p < NUM_PHASES; p++) begin
      write_tap_count(phase_taps[p]);
      // every third phase the sender never idles
      steady_mode = (p % 3 == 2);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
        for (k = 0; k < seq_len; k++) begin
          if ($urandom_range(0, 7) == 0) begin
            send_item(lcf_pkg::ActLoad, $urandom_range(0, MAX_TAPS - 1), pick_value(),
                      1'($urandom_range(0, 1)));
            sent++;
          end
          // once, hold off mid-sequence until the core has emptied
          if (p == 1 && !paused && sent >= ITEMS_PER_PHASE / 2) begin
            wait_drained();
            paused = 1'b1;
          end
          send_item(lcf_pkg::ActSample, $urandom_range(0, MAX_TAPS - 1), pick_value(),
                    k == seq_len - 1);
          sent++;
        end
      end
      wait_drained();
    end

    $display("run covered %0d tap loads and %0d samples over %0d tap count settings,",
             loads_sent, samples_sent, NUM_PHASES + 2);
    $display("  %0d convolution outputs checked under sender gaps and receiver stalls",
             outputs_seen);
    if (mismatch_count == 0 && outputs_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/lcf_pkg.sv
sv/lcf_ram.sv
sv/linear_convolution_fir_core.sv
test/fir_conv_checker.sv
test/testbench.sv
